@@ hw/rtl/itdt_pkg.sv @@
package itdt_pkg;

	localparam int unsigned MAG_W = 31;
	localparam int unsigned POS_W = 4;
	localparam int unsigned CMP_W = 34;
	localparam int unsigned MAX_POS = 9;

	localparam logic [7:0] CHAR_N = 8'h4E;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [31:0] MISSING_MARK = 32'h8000_0000;

	localparam logic [7:0] SEP_CHAR_RESET = 8'd44;
	localparam logic SEP_EN_RESET = 1'b1;

	localparam logic CFG_SEP_CHAR = 1'b0;
	localparam logic CFG_SEP_EN = 1'b1;

	localparam logic [CMP_W-1:0] POW10 [MAX_POS+1] = '{
		34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
		34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
	};

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [POS_W-1:0] top_pos;
		logic neg;
		logic missing;
		logic sep;
		logic ends_row;
	} itdt_entry_t;

endpackage

@@ hw/rtl/itdt_if.sv @@
interface itdt_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] value;
	logic ends_row;

	modport source (output valid, output value, output ends_row, input ready);
	modport sink (input valid, input value, input ends_row, output ready);
endinterface

interface itdt_out_if;
	logic valid;
	logic ready;
	logic [7:0] text_char;
	logic last_of_value;
	logic row_done;

	modport source (output valid, output text_char, output last_of_value,
		output row_done, input ready);
	modport sink (input valid, input text_char, input last_of_value,
		input row_done, output ready);
endinterface

@@ hw/rtl/int_row_to_decimal_text.sv @@
// An accepted beat is registered into the queue; its first character beat then
// passes through the back part's state register and its registered output when the
// back part is idle, and is held back while earlier values are spelled out or stalled.
// Throughput: one character beat per cycle while the sink is ready; a value is 1 to
// 12 characters (separator, sign, up to ten digits).
// Reset (arst_n low, asynchronous): queue empty, no output beat pending, next
// value begins a row, separator ',' and separators enabled.
module int_row_to_decimal_text
	import itdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	itdt_in_if.sink    items,
	itdt_out_if.source text,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	// Configuration registers. The user must write them only while the block is idle,
	// which the block itself does not enforce, so the front and back parts may read them directly.
	logic [7:0] sep_char_q;
	logic sep_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_char_q <= SEP_CHAR_RESET;
			sep_en_q <= SEP_EN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEP_CHAR: sep_char_q <= cfg_data;
				CFG_SEP_EN: sep_en_q <= cfg_data[0];
				default: sep_en_q <= sep_en_q;
			endcase
		end
	end

	// The front part classifies each value: missing marker, sign, magnitude,
	// top digit position, and whether a separator goes ahead of it in its row.
	logic push;
	logic full;
	itdt_entry_t push_entry;

	itdt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.sep_en     (sep_en_q),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// A two-entry queue lets the front keep accepting while the back is
	// still spelling out a long value or is stalled by the sink.
	logic pop;
	logic q_valid;
	itdt_entry_t q_entry;

	itdt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	// The back part emits one character per cycle, while the sink is ready, into a
	// registered output, taking the next queued value on the cycle of the final character.
	itdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.pop      (pop),
		.sep_char (sep_char_q),
		.text     (text)
	);

endmodule

@@ hw/rtl/itdt_front.sv @@
module itdt_front
	import itdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	itdt_in_if.sink     items,
	input  logic        sep_en,
	input  logic        full,
	output logic        push,
	output itdt_entry_t push_entry
);

	logic at_row_start_q;
	logic [31:0] mag32;
	logic [MAG_W-1:0] mag;
	logic [POS_W-1:0] top_pos;

	assign items.ready = !full;
	assign push = items.valid && !full;

	always_comb begin
		mag32 = items.value[31] ? (32'd0 - items.value) : items.value;
		mag = mag32[MAG_W-1:0];
	end

	// Top digit position: the exponent of the highest power of ten not above the magnitude.
	always_comb begin
		top_pos = '0;
		for (int p = 1; p <= MAX_POS; p++) begin
			if ({3'b000, mag} >= POW10[p]) begin
				top_pos = POS_W'(p);
			end
		end
	end

	always_comb begin
		push_entry.mag = mag;
		push_entry.top_pos = top_pos;
		push_entry.neg = items.value[31];
		push_entry.missing = (items.value == MISSING_MARK);
		push_entry.sep = !at_row_start_q && sep_en;
		push_entry.ends_row = items.ends_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_row_start_q <= 1'b1;
		end else if (push) begin
			at_row_start_q <= items.ends_row;
		end
	end

endmodule

@@ hw/rtl/itdt_queue.sv @@
module itdt_queue
	import itdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  itdt_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        q_valid,
	output itdt_entry_t q_entry
);

	itdt_entry_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/itdt_back.sv @@
module itdt_back
	import itdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  itdt_entry_t q_entry,
	output logic        pop,
	input  logic [7:0]  sep_char,
	itdt_out_if.source  text
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SEP   = 3'd1;
	localparam logic [2:0] ST_SIGN  = 3'd2;
	localparam logic [2:0] ST_DIGIT = 3'd3;
	localparam logic [2:0] ST_NA_N  = 3'd4;
	localparam logic [2:0] ST_NA_A  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [MAG_W-1:0] rem_q;
	logic [POS_W-1:0] pos_q;
	logic neg_q;
	logic missing_q;
	logic ends_row_q;

	logic out_valid_q;
	logic [7:0] out_char_q;
	logic out_last_q;
	logic out_row_q;

	logic adv;
	logic last_char;
	logic [3:0] digit;
	logic [CMP_W-1:0] sub;
	logic [7:0] ch;

	assign text.valid = out_valid_q;
	assign text.text_char = out_char_q;
	assign text.last_of_value = out_last_q;
	assign text.row_done = out_row_q;

	assign adv = (state_q != ST_IDLE) && (!out_valid_q || text.ready);
	assign last_char = (state_q == ST_NA_A) || ((state_q == ST_DIGIT) && (pos_q == '0));
	assign pop = q_valid && ((state_q == ST_IDLE) || (adv && last_char));

	// One digit per cycle while the output is not stalled: the largest multiple of the current power of ten.
	always_comb begin
		digit = '0;
		sub = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({3'b000, rem_q} >= POW10[pos_q] * CMP_W'(k)) begin
				digit = 4'(k);
				sub = POW10[pos_q] * CMP_W'(k);
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_SEP: ch = sep_char;
			ST_SIGN: ch = CHAR_MINUS;
			ST_DIGIT: ch = CHAR_ZERO + {4'd0, digit};
			ST_NA_N: ch = CHAR_N;
			ST_NA_A: ch = CHAR_A;
			default: ch = '0;
		endcase
	end

	function automatic logic [2:0] first_state(input itdt_entry_t e);
		if (e.sep) begin
			return ST_SEP;
		end else if (e.missing) begin
			return ST_NA_N;
		end else if (e.neg) begin
			return ST_SIGN;
		end
		return ST_DIGIT;
	endfunction

	always_comb begin
		state_d = state_q;
		if (pop) begin
			state_d = first_state(q_entry);
		end else if (adv) begin
			case (state_q)
				ST_SEP: state_d = missing_q ? ST_NA_N : (neg_q ? ST_SIGN : ST_DIGIT);
				ST_SIGN: state_d = ST_DIGIT;
				ST_NA_N: state_d = ST_NA_A;
				ST_NA_A: state_d = ST_IDLE;
				ST_DIGIT: state_d = (pos_q == '0) ? ST_IDLE : ST_DIGIT;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= q_entry.mag;
			pos_q <= q_entry.top_pos;
			neg_q <= q_entry.neg;
			missing_q <= q_entry.missing;
			ends_row_q <= q_entry.ends_row;
		end else if (adv && (state_q == ST_DIGIT)) begin
			rem_q <= rem_q - sub[MAG_W-1:0];
			pos_q <= pos_q - POS_W'(1);
		end
		if (adv) begin
			out_char_q <= ch;
			out_last_q <= last_char;
			out_row_q <= last_char && ends_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_row_implies_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_row_q |-> out_last_q)
		else $error("row_done without last_of_value");

	a_digit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT) |-> (pos_q <= POS_W'(MAX_POS)) &&
		({3'b000, rem_q} < POW10[pos_q] * CMP_W'(10)))
		else $error("remainder exceeds current digit position");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid && ((state_q == ST_IDLE) || last_char))
		else $error("queue popped before current value finished");

endmodule
